// ===== sv/update_image_packet_receiver_core_defines.svh =====
// Assertion helpers shared by the receiver RTL.
`ifndef UPDATE_IMAGE_PACKET_RECEIVER_CORE_DEFINES_SVH
`define UPDATE_IMAGE_PACKET_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define UIPR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("uipr assertion failed");
`define UIPR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("uipr assertion failed");
`else
`define UIPR_ASSERT(label, clk, rst, prop)
`define UIPR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== sv/uipr_pkg.sv =====
package uipr_pkg;

   localparam int unsigned LenWidth  = 13;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned ReqDataWidth = 72;
   localparam int unsigned RspDataWidth = 48;

   localparam logic [LenWidth-1:0]  DEFAULT_PKT_LEN = 13'd964;
   localparam logic [WordWidth-1:0] CRC_POLY = 32'hEDB8_8320;

   // request kinds (req_tuser / rsp_tuser)
   localparam logic [1:0] FUNC_FILE_INFO = 2'd0;
   localparam logic [1:0] FUNC_DATA      = 2'd1;
   localparam logic [1:0] FUNC_PKT_CRC   = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_WAIT_DATA = 4'b0010,
      PH_WAIT_CRC  = 4'b0100,
      PH_DONE      = 4'b1000
   } phase_type;

   // reflected CRC-32, one byte, eight shift steps flattened into an XOR net
   function automatic logic [WordWidth-1:0] uipr_crc_byte(
      input logic [WordWidth-1:0] crc,
      input logic [7:0]           data
   );
      logic [WordWidth-1:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

endpackage

// ===== sv/update_image_packet_receiver_core.sv =====
// Channel | Dir | Handshake             | Payload
// req     | in  | req_tvalid/req_tready | tuser: func; tdata: data_byte, image_size, check_value
// rsp     | out | rsp_tvalid/rsp_tready | tuser: reply_to; tdata: ack, crc_echo, length_echo,
//         |     |                       |        update_done
// csr     | in  | csr_valid/csr_ready   | data: pkt_len
//
// Two register stages: a request register and a response register. One request per
// cycle while req_tready is high; each response is registered from the request register.
// The byte CRC update and the packet-goal subtract/compare sit between the two stages.
// A request that needs a response holds in the request register while the response
// register waits for rsp_tready; req_tready is low then.
// Synchronous active-high reset clears phase, counters and CRC; pkt_len -> 964.
// Requests that give no response (mid-packet data bytes, kind 3) never stall.
`include "update_image_packet_receiver_core_defines.svh"

module update_image_packet_receiver_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] data_byte, [39:8] image_size, [71:40] check_value
   input  logic [uipr_pkg::ReqDataWidth-1:0]   req_tdata,
   // [1:0] func
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] ack, [32:1] crc_echo, [45:33] length_echo, [46] update_done, [47] zero
   output logic [uipr_pkg::RspDataWidth-1:0]   rsp_tdata,
   // [1:0] reply_to
   output logic [1:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [uipr_pkg::LenWidth-1:0]       csr_data
);
   import uipr_pkg::*;

   // configuration
   logic [LenWidth-1:0]  pkt_len_ff;

   // request register
   logic                 in_valid_ff;
   logic [1:0]           in_func_ff;
   logic [7:0]           in_byte_ff;
   logic [WordWidth-1:0] in_size_ff;
   logic [WordWidth-1:0] in_check_ff;

   // transfer state
   phase_type            phase_ff, phase_in;
   logic [WordWidth-1:0] image_bytes_ff, image_bytes_in;
   logic [WordWidth-1:0] written_ff, written_in;
   logic [WordWidth-1:0] remaining_ff, remaining_in;   // image_bytes - written
   logic [LenWidth-1:0]  pkt_bytes_ff, pkt_bytes_in;
   logic [LenWidth-1:0]  pkt_goal_ff, pkt_goal_in;
   logic [WordWidth-1:0] crc_ff, crc_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_kind_ff;
   logic                 rsp_ack_ff;
   logic [WordWidth-1:0] rsp_crc_ff;
   logic [LenWidth-1:0]  rsp_len_ff;
   logic                 rsp_done_ff;

   logic                 has_result;
   logic                 res_ack;
   logic [WordWidth-1:0] res_crc;
   logic [LenWidth-1:0]  res_len;
   logic                 res_done;
   logic                 advance;
   logic                 fail;

   logic [WordWidth-1:0] crc_next;
   logic [LenWidth:0]    pkt_inc;
   logic [WordWidth-1:0] sum_written;
   logic [WordWidth-1:0] rem_after;
   logic [WordWidth-1:0] rem_file;
   logic [WordWidth-1:0] rem_sel;
   logic [LenWidth-1:0]  goal_sel;
   logic                 in_packet;

   assign csr_ready = 1'b1;

   // shared datapath terms
   always_comb begin
      crc_next    = uipr_crc_byte(crc_ff, in_byte_ff);
      pkt_inc     = {1'b0, pkt_bytes_ff} + {{LenWidth{1'b0}}, 1'b1};
      sum_written = written_ff + {{(WordWidth-LenWidth){1'b0}}, pkt_bytes_ff};
      rem_after   = remaining_ff - {{(WordWidth-LenWidth){1'b0}}, pkt_bytes_ff};
      rem_file    = in_size_ff - written_ff;
      rem_sel     = (in_func_ff == FUNC_FILE_INFO) ? rem_file : rem_after;
      goal_sel    = (rem_sel >= {{(WordWidth-LenWidth){1'b0}}, pkt_len_ff}) ?
                    pkt_len_ff : rem_sel[LenWidth-1:0];
      in_packet   = (phase_ff == PH_WAIT_DATA) || (phase_ff == PH_WAIT_CRC);
   end

   // response decision for the item in the request register
   always_comb begin
      has_result = 1'b0;
      fail       = 1'b0;
      res_ack    = 1'b0;
      res_crc    = '0;
      res_len    = '0;
      res_done   = 1'b0;
      if (in_valid_ff) begin
         priority if (in_func_ff == FUNC_FILE_INFO) begin
            has_result = 1'b1;
            res_len    = pkt_len_ff;
         end else if (in_func_ff == FUNC_DATA) begin
            if (!in_packet || (pkt_inc > {1'b0, pkt_goal_ff})) begin
               fail       = 1'b1;
               has_result = 1'b1;
               res_ack    = 1'b1;
            end else if (pkt_inc >= {1'b0, pkt_goal_ff}) begin
               has_result = 1'b1;
            end
         end else if (in_func_ff == FUNC_PKT_CRC) begin
            has_result = 1'b1;
            if (phase_ff != PH_WAIT_CRC) begin
               fail    = 1'b1;
               res_ack = 1'b1;
            end else if (crc_ff != in_check_ff) begin
               fail    = 1'b1;
               res_ack = 1'b1;
               res_crc = crc_ff;
            end else begin
               res_crc  = crc_ff;
               res_done = (sum_written >= image_bytes_ff);
            end
         end else begin
            has_result = 1'b0;
         end
      end
   end

   assign advance    = in_valid_ff && (!has_result || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // state update
   always_comb begin
      phase_in       = phase_ff;
      image_bytes_in = image_bytes_ff;
      written_in     = written_ff;
      remaining_in   = remaining_ff;
      pkt_bytes_in   = pkt_bytes_ff;
      pkt_goal_in    = pkt_goal_ff;
      crc_in         = crc_ff;
      if (advance) begin
         if (fail) begin
            phase_in       = PH_IDLE;
            image_bytes_in = '0;
            written_in     = '0;
            remaining_in   = '0;
            pkt_bytes_in   = '0;
            pkt_goal_in    = '0;
            crc_in         = '0;
         end else if (in_func_ff == FUNC_FILE_INFO) begin
            phase_in       = PH_WAIT_DATA;
            image_bytes_in = in_size_ff;
            remaining_in   = rem_file;
            pkt_bytes_in   = '0;
            pkt_goal_in    = goal_sel;
            crc_in         = '0;
         end else if (in_func_ff == FUNC_DATA) begin
            crc_in       = crc_next;
            pkt_bytes_in = pkt_inc[LenWidth-1:0];
            if (pkt_inc >= {1'b0, pkt_goal_ff}) begin
               phase_in = PH_WAIT_CRC;
            end
         end else if (in_func_ff == FUNC_PKT_CRC) begin
            crc_in = '0;
            if (res_done) begin
               phase_in     = PH_DONE;
               written_in   = '0;
               remaining_in = image_bytes_ff;
            end else begin
               phase_in     = PH_WAIT_DATA;
               written_in   = sum_written;
               remaining_in = rem_after;
               pkt_bytes_in = '0;
               pkt_goal_in  = goal_sel;
            end
         end
      end
   end

   always_comb begin
      if (advance && has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_len_ff     <= DEFAULT_PKT_LEN;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= PH_IDLE;
         image_bytes_ff <= '0;
         written_ff     <= '0;
         remaining_ff   <= '0;
         pkt_bytes_ff   <= '0;
         pkt_goal_ff    <= '0;
         crc_ff         <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            pkt_len_ff <= csr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         rsp_valid_ff   <= rsp_valid_in;
         phase_ff       <= phase_in;
         image_bytes_ff <= image_bytes_in;
         written_ff     <= written_in;
         remaining_ff   <= remaining_in;
         pkt_bytes_ff   <= pkt_bytes_in;
         pkt_goal_ff    <= pkt_goal_in;
         crc_ff         <= crc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff  <= req_tuser;
         in_byte_ff  <= req_tdata[7:0];
         in_size_ff  <= req_tdata[39:8];
         in_check_ff <= req_tdata[71:40];
      end
      if (advance && has_result) begin
         rsp_kind_ff <= in_func_ff;
         rsp_ack_ff  <= res_ack;
         rsp_crc_ff  <= res_crc;
         rsp_len_ff  <= res_len;
         rsp_done_ff <= res_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {1'b0, rsp_done_ff, rsp_len_ff, rsp_crc_ff, rsp_ack_ff};

   `UIPR_ASSERT(a_pkt_within_goal, clock, reset, pkt_bytes_ff <= pkt_goal_ff)
   `UIPR_ASSERT(a_remaining_tracks, clock, reset,
                remaining_ff == image_bytes_ff - written_ff)
   `UIPR_ASSERT(a_error_clears, clock, reset,
                advance && fail |=> phase_ff == PH_IDLE && written_ff == '0)
   `UIPR_ASSERT(a_done_only_on_crc_ok, clock, reset,
                rsp_valid_ff && rsp_done_ff |-> rsp_kind_ff == FUNC_PKT_CRC && !rsp_ack_ff)

endmodule
